### rtl/distance_to_gated_volume_map_core_macros.svh
// Assertion macros for the distance to gated volume map core.
`ifndef DISTANCE_TO_GATED_VOLUME_MAP_CORE_MACROS_SVH
`define DISTANCE_TO_GATED_VOLUME_MAP_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define DGVM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgvm check failed");

// Check a consequence in the cycle after its cause.
`define DGVM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgvm check failed");

`endif

### rtl/dgvm_pkg.sv
// Shared constants, types and the exponent factor table of the volume map core.
package dgvm_pkg;

    localparam int DISTANCE_BITS = 16;

    localparam logic [2:0] CFG_NEAR     = 3'd0;
    localparam logic [2:0] CFG_FAR      = 3'd1;
    localparam logic [2:0] CFG_GATE     = 3'd2;
    localparam logic [2:0] CFG_FLOOR    = 3'd3;
    localparam logic [2:0] CFG_CEILING  = 3'd4;
    localparam logic [2:0] CFG_EXPONENT = 3'd5;

    localparam logic [15:0] NEAR_RESET     = 16'd50;
    localparam logic [15:0] FAR_RESET      = 16'd500;
    localparam logic [15:0] GATE_RESET     = 16'd0;
    localparam logic [15:0] FLOOR_RESET    = 16'd0;
    localparam logic [15:0] CEILING_RESET  = 16'hFFFF;
    localparam logic [15:0] EXPONENT_RESET = 16'd4096;

    localparam int DIV_STEPS     = 33;
    localparam int LOG_STEPS     = 28;
    localparam int EXP_STEPS     = 24;
    localparam int UNDERFLOW_INT = 17;

    localparam int ST_FRONT   = 1;
    localparam int ST_DIV0    = ST_FRONT + 1;
    localparam int ST_NORM    = ST_DIV0 + DIV_STEPS;
    localparam int ST_LOG0    = ST_NORM + 1;
    localparam int ST_LOGV    = ST_LOG0 + LOG_STEPS;
    localparam int ST_T       = ST_LOGV + 1;
    localparam int ST_EXP0    = ST_T + 1;
    localparam int ST_SHIFT   = ST_EXP0 + EXP_STEPS;
    localparam int ST_FINAL   = ST_SHIFT + 1;
    localparam int PIPE_DEPTH = ST_FINAL + 1;

    typedef struct packed {
        logic err;
        logic gated;
        logic zero;
        logic unity;
    } flags_t;

    typedef logic [31:0] factor_tab_t [EXP_STEPS];

    function automatic logic [31:0] isqrt64(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] cand;
        r = '0;
        for (int k = 31; k >= 0; k--) begin
            cand = r | (32'd1 << k);
            if (64'(cand) * 64'(cand) <= v)
                r = cand;
        end
        return r;
    endfunction

    // Factor i is 2^(-2^-(i+1)) in Q0.32, each by truncating square roots of one half.
    function automatic factor_tab_t build_factors();
        factor_tab_t tab;
        logic [31:0] f;
        f = 32'h8000_0000;
        for (int i = 0; i < EXP_STEPS; i++) begin
            f = isqrt64({f, 32'h0});
            tab[i] = f;
        end
        return tab;
    endfunction

    localparam factor_tab_t EXP_FACTOR = build_factors();

endpackage

### rtl/distance_to_gated_volume_map_core.sv
// Top level of the distance to gated volume map core: a fully pipelined datapath.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   config   | cfg_write                  | cfg_index, cfg_data
//   input    | in_valid / in_ready        | sensor_mm
//   output   | out_valid / out_ready      | volume, gated, config_error
//
// One transaction enters per cycle unless the output stalls; each result passes through
// 92 register stages.
// The depth comes from the 33-step restoring divider, 28 squaring steps of the
// log2 unit and 24 multiply steps of the exp2 unit, one step per stage.
// A stall at the output freezes every stage at once: in_ready = !out_valid | out_ready.
// Reset clears the valid line and loads the configuration defaults.

`include "distance_to_gated_volume_map_core_macros.svh"

module distance_to_gated_volume_map_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sensor_mm,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] volume,
    output logic        gated,
    output logic        config_error
);

    localparam int DB    = dgvm_pkg::DISTANCE_BITS;
    localparam int NDIV  = dgvm_pkg::DIV_STEPS;
    localparam int NLOG  = dgvm_pkg::LOG_STEPS;
    localparam int NEXP  = dgvm_pkg::EXP_STEPS;
    localparam int DEPTH = dgvm_pkg::PIPE_DEPTH;

    // ---------------------------------------------------------------- config
    logic [15:0] near_reg, far_reg, gate_reg, floor_reg, ceiling_reg, exponent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg     <= dgvm_pkg::NEAR_RESET;
            far_reg      <= dgvm_pkg::FAR_RESET;
            gate_reg     <= dgvm_pkg::GATE_RESET;
            floor_reg    <= dgvm_pkg::FLOOR_RESET;
            ceiling_reg  <= dgvm_pkg::CEILING_RESET;
            exponent_reg <= dgvm_pkg::EXPONENT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dgvm_pkg::CFG_NEAR:     near_reg     <= cfg_data;
                dgvm_pkg::CFG_FAR:      far_reg      <= cfg_data;
                dgvm_pkg::CFG_GATE:     gate_reg     <= cfg_data;
                dgvm_pkg::CFG_FLOOR:    floor_reg    <= cfg_data;
                dgvm_pkg::CFG_CEILING:  ceiling_reg  <= cfg_data;
                dgvm_pkg::CFG_EXPONENT: exponent_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------ valid and flags
    logic                  adv;
    logic [DEPTH-1:0]      valid_reg;
    dgvm_pkg::flags_t      flag_reg [DEPTH];
    dgvm_pkg::flags_t      flag_next [DEPTH];
    dgvm_pkg::flags_t      front_flags;
    logic                  norm_zero;
    logic                  norm_unity;
    logic                  underflow;

    // Advance the whole pipeline whenever the output slot is free or being taken.
    assign adv       = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
    end

    always_comb
    begin
        flag_next[0] = '0;
        for (int k = 1; k < DEPTH; k++)
            flag_next[k] = flag_reg[k-1];
        // Special stages inject their findings over the plain shift.
        flag_next[dgvm_pkg::ST_FRONT] = front_flags;
        flag_next[dgvm_pkg::ST_NORM].zero  = flag_reg[dgvm_pkg::ST_NORM-1].zero | norm_zero;
        flag_next[dgvm_pkg::ST_NORM].unity = norm_unity;
        flag_next[dgvm_pkg::ST_EXP0].zero  = flag_reg[dgvm_pkg::ST_EXP0-1].zero | underflow;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DEPTH; k++)
                flag_reg[k] <= flag_next[k];
        end
    end

    // ------------------------------------------------------- input capture
    logic [DB-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            dist_reg <= sensor_mm[DB-1:0];
    end

    // --------------------------------- clamp, gate test, divider operands
    logic [DB-1:0] nv, fv, dc, span;
    logic [15:0]   span16;
    logic [31:0]   lhs, rhs, front_num;
    logic [32:0]   front_den;
    logic [31:0]   front_num_reg;
    logic [32:0]   front_den_reg;

    always_comb
    begin
        nv     = near_reg[DB-1:0];
        fv     = far_reg[DB-1:0];
        dc     = (dist_reg < nv) ? nv : ((dist_reg > fv) ? fv : dist_reg);
        span   = fv - nv;
        span16 = 16'(span);
        lhs    = {16'(fv - dc), 16'h0};
        rhs    = gate_reg * span16;
        // Unless gated or in config error, num <= den holds, so the quotient never exceeds 1.0 in Q1.32.
        front_num = lhs - rhs;
        front_den = {1'b0, span16, 16'h0} - {1'b0, rhs};
        front_flags.err   = (fv <= nv);
        front_flags.gated = (fv > nv) && (lhs <= rhs);
        front_flags.zero  = 1'b0;
        front_flags.unity = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_num_reg <= front_num;
            front_den_reg <= front_den;
        end
    end

    // ------------------------------------- restoring divider, bit per stage
    logic [32:0] div_rem_reg [NDIV];
    logic [32:0] div_quo_reg [NDIV];
    logic [32:0] div_den_reg [NDIV];
    logic [32:0] div_rem_src [NDIV+1];
    logic [32:0] div_quo_src [NDIV+1];
    logic [32:0] div_den_src [NDIV+1];
    logic [32:0] div_rem_nxt [NDIV];
    logic [32:0] div_quo_nxt [NDIV];

    always_comb
    begin
        logic [33:0] sh;
        logic        ge;
        div_rem_src[0] = {2'b00, front_num_reg[31:1]};
        div_quo_src[0] = '0;
        div_den_src[0] = front_den_reg;
        for (int j = 0; j < NDIV; j++)
        begin
            div_rem_src[j+1] = div_rem_reg[j];
            div_quo_src[j+1] = div_quo_reg[j];
            div_den_src[j+1] = div_den_reg[j];
        end
        for (int j = 0; j < NDIV; j++)
        begin
            // Only the first step brings in a dividend bit; the rest are zeros.
            sh = {div_rem_src[j], (j == 0) ? front_num_reg[0] : 1'b0};
            ge = (sh >= {1'b0, div_den_src[j]});
            div_rem_nxt[j] = ge ? 33'(sh - {1'b0, div_den_src[j]}) : sh[32:0];
            div_quo_nxt[j] = {div_quo_src[j][31:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < NDIV; j++)
            begin
                div_rem_reg[j] <= div_rem_nxt[j];
                div_quo_reg[j] <= div_quo_nxt[j];
                div_den_reg[j] <= div_den_src[j];
            end
        end
    end

    // ------------------------------------------------------- normalization
    logic [32:0] q;
    logic [4:0]  lz;
    logic [31:0] norm_y_reg;
    logic [4:0]  norm_s_reg;

    always_comb
    begin
        q  = div_quo_reg[NDIV-1];
        lz = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (q[k])
                lz = 5'(31 - k);
        end
        norm_zero  = (q == 33'h0);
        norm_unity = q[32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_y_reg <= q[31:0] << lz;
            norm_s_reg <= lz;
        end
    end

    // -------------------------------------- log2 fraction by squaring steps
    logic [31:0] log_y_reg [NLOG];
    logic [27:0] log_f_reg [NLOG];
    logic [4:0]  log_s_reg [NLOG];
    logic [31:0] log_y_src [NLOG+1];
    logic [27:0] log_f_src [NLOG+1];
    logic [4:0]  log_s_src [NLOG+1];
    logic [31:0] log_y_nxt [NLOG];
    logic [27:0] log_f_nxt [NLOG];

    always_comb
    begin
        logic [63:0] sq;
        logic [32:0] tq;
        log_y_src[0] = norm_y_reg;
        log_f_src[0] = '0;
        log_s_src[0] = norm_s_reg;
        for (int i = 0; i < NLOG; i++)
        begin
            log_y_src[i+1] = log_y_reg[i];
            log_f_src[i+1] = log_f_reg[i];
            log_s_src[i+1] = log_s_reg[i];
        end
        for (int i = 0; i < NLOG; i++)
        begin
            sq = 64'(log_y_src[i]) * 64'(log_y_src[i]);
            tq = sq[63:31];
            log_y_nxt[i] = tq[32] ? tq[32:1] : tq[31:0];
            log_f_nxt[i] = {log_f_src[i][26:0], tq[32]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NLOG; i++)
            begin
                log_y_reg[i] <= log_y_nxt[i];
                log_f_reg[i] <= log_f_nxt[i];
                log_s_reg[i] <= log_s_src[i];
            end
        end
    end

    // ---------------------------------------- -log2 q, then t = e * -log2 q
    logic [33:0] lval_reg;
    logic [49:0] t_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (flag_reg[dgvm_pkg::ST_LOGV-1].unity)
                lval_reg <= '0;
            else
                lval_reg <= {(6'(log_s_src[NLOG]) + 6'd1), 28'h0} - 34'(log_f_src[NLOG]);
            t_reg <= 50'(exponent_reg) * 50'(lval_reg);
        end
    end

    assign underflow = (t_reg[49:40] >= 10'(dgvm_pkg::UNDERFLOW_INT));

    // ---------------------------------- exp2 fraction by constant factors
    logic [32:0] exp_acc_reg  [NEXP];
    logic [23:0] exp_frac_reg [NEXP];
    logic [4:0]  exp_n_reg    [NEXP];
    logic [32:0] exp_acc_src  [NEXP+1];
    logic [23:0] exp_frac_src [NEXP+1];
    logic [4:0]  exp_n_src    [NEXP+1];
    logic [32:0] exp_acc_nxt  [NEXP];

    always_comb
    begin
        logic [64:0] prod;
        exp_acc_src[0]  = 33'h1_0000_0000;
        exp_frac_src[0] = t_reg[39:16];
        exp_n_src[0]    = t_reg[44:40];
        for (int m = 0; m < NEXP; m++)
        begin
            exp_acc_src[m+1]  = exp_acc_reg[m];
            exp_frac_src[m+1] = exp_frac_reg[m];
            exp_n_src[m+1]    = exp_n_reg[m];
        end
        for (int m = 0; m < NEXP; m++)
        begin
            prod = 65'(exp_acc_src[m]) * 65'(dgvm_pkg::EXP_FACTOR[m]);
            exp_acc_nxt[m] = exp_frac_src[m][NEXP-1-m] ? prod[64:32] : exp_acc_src[m];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < NEXP; m++)
            begin
                exp_acc_reg[m]  <= exp_acc_nxt[m];
                exp_frac_reg[m] <= exp_frac_src[m];
                exp_n_reg[m]    <= exp_n_src[m];
            end
        end
    end

    // ------------------------------------------ integer shift, linear map
    logic [32:0]        shaped_reg;
    logic [15:0]        volume_reg;
    logic signed [16:0] diff;
    logic signed [50:0] mprod;
    logic signed [51:0] vacc;
    logic [51:0]        rnd;
    dgvm_pkg::flags_t   fin_flags;

    always_comb
    begin
        fin_flags = flag_reg[dgvm_pkg::ST_FINAL-1];
        diff  = $signed({1'b0, ceiling_reg}) - $signed({1'b0, floor_reg});
        mprod = $signed({1'b0, shaped_reg}) * diff;
        vacc  = $signed({4'b0000, floor_reg, 32'h0}) + 52'(mprod);
        rnd   = vacc[51] ? 52'h0 : (52'(vacc) + (52'd1 << 31));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (flag_reg[dgvm_pkg::ST_SHIFT-1].zero)
                shaped_reg <= '0;
            else
                shaped_reg <= exp_acc_src[NEXP] >> exp_n_src[NEXP];
            if (fin_flags.err || fin_flags.gated)
                volume_reg <= '0;
            else
                volume_reg <= rnd[47:32];
        end
    end

    assign volume       = volume_reg;
    assign gated        = flag_reg[DEPTH-1].gated;
    assign config_error = flag_reg[DEPTH-1].err;

    // ---------------------------------------------------------- assertions
    `DGVM_ASSERT_NOW(a_err_silent, out_valid && config_error, volume == 16'h0 && !gated)
    `DGVM_ASSERT_NOW(a_gate_silent, out_valid && gated, volume == 16'h0 && !config_error)
    `DGVM_ASSERT_NEXT(a_stall_hold, !in_ready, $stable(valid_reg))

endmodule
